// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/srcd_pkg.sv -----
package srcd_pkg;

   localparam int MAX_CHIPS_DEF = 8;
   localparam int BITS_PER_CHIP = 8;

   localparam logic [2:0] FUNC_WRITE_BYTE = 3'd0;
   localparam logic [2:0] FUNC_CLEAR_CHIP = 3'd1;
   localparam logic [2:0] FUNC_SET_ALL    = 3'd2;
   localparam logic [2:0] FUNC_CLEAR_ALL  = 3'd3;
   localparam logic [2:0] FUNC_SET_BIT    = 3'd4;
   localparam logic [2:0] FUNC_CLEAR_BIT  = 3'd5;

   localparam logic [7:0] BYTE_ONES = 8'hff;
   localparam logic [7:0] BYTE_ZERO = 8'h00;
   localparam logic [7:0] BIT_ONE   = 8'h01;
   localparam logic [2:0] BIT_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0] func;
      logic [3:0] chip_index;
      logic [7:0] data_byte;
      logic [5:0] bit_index;
   } req_type;

   typedef struct packed {
      logic serial_bit;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_MODIFY,
      ST_PREP,
      ST_LOAD,
      ST_SHIFT
   } state_type;

endpackage

// ----- rtl/shift_register_chain_driver.sv -----
// Driver for a chain of serial-in parallel-out shift register chips.
// req channel: one command (func, chip_index, data_byte, bit_index) per
// request. The command updates the byte shadow, then the whole chain is
// shifted out on the rsp channel, one serial_bit per response, starting at
// the highest live chip, MSB first; last marks the final bit. Malformed
// requests (func 6 or 7, or write byte / clear chip with chip index 0 or
// above MAX_CHIPS) are taken and produce no responses.
// csr channel: chip_count (0 reads as 1, clipped at MAX_CHIPS); always ready,
// write it only while idle.
// Sequence: exec, then a fill pass over the live chips (set all / clear
// all) or a read-modify-write step (set / clear bit), then prep and load,
// then the shift of 8 bits per live chip. The next byte is prefetched from
// the shadow RAM during the shift, so the single RAM port never stalls the
// bit stream. One command is in flight at a time; req_ready is low from
// acceptance until the cycle after the last bit is taken. A stalled
// receiver holds the current bit; nothing is lost.
// Reset clears the shadow (via per-chip valid bits) and sets chip_count to 1.
module shift_register_chain_driver #(
   parameter int MAX_CHIPS = srcd_pkg::MAX_CHIPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  srcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output srcd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);
   import srcd_pkg::*;

   localparam int ADDR_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

   logic [3:0]        chip_count_ff;
   logic [3:0]        chip_count_in;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_addr;
   logic [7:0]        mem_wdata;
   logic [7:0]        mem_rdata;

   assign csr_ready     = 1'b1;
   assign chip_count_in = (csr_valid && csr_ready) ? csr_data : chip_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_count_ff <= 4'd1;
      end else begin
         chip_count_ff <= chip_count_in;
      end
   end

   srcd_seq #(
      .MAX_CHIPS(MAX_CHIPS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .chip_count(chip_count_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   srcd_shadow #(
      .MAX_CHIPS(MAX_CHIPS)
   ) u_shadow (
      .clock(clock),
      .reset(reset),
      .ctl  (mem_ctl),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );
endmodule

// ----- rtl/srcd_ram.sv -----
module srcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                       wdata,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/srcd_shadow.sv -----
`include "assert_macros.svh"

module srcd_shadow #(
   parameter int MAX_CHIPS = srcd_pkg::MAX_CHIPS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  srcd_pkg::mem_ctl_type                          ctl,
   input  logic [((MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1)-1:0] addr,
   input  logic [7:0]                                     wdata,
   output logic [7:0]                                     rdata
);
   import srcd_pkg::*;

   logic [MAX_CHIPS-1:0] valid_ff;
   logic [MAX_CHIPS-1:0] valid_in;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   logic [7:0]           ram_rdata;

   srcd_ram #(
      .WIDTH(8),
      .DEPTH(MAX_CHIPS)
   ) u_ram (
      .clock(clock),
      .we   (ctl.wr),
      .re   (ctl.rd),
      .addr (addr),
      .wdata(wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (ctl.wr) begin
         valid_in[addr] = 1'b1;
      end
      if (ctl.rd) begin
         rd_valid_in = valid_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // never-written bytes read as zero
   assign rdata = rd_valid_ff ? ram_rdata : BYTE_ZERO;

   `ASSERT_IMPLIES(a_rd_valid_hold, clock, reset, !$past(ctl.rd),
                   rd_valid_ff == $past(rd_valid_ff), "read valid changed without a read")
endmodule

// ----- rtl/srcd_seq.sv -----
`include "assert_macros.svh"

module srcd_seq #(
   parameter int MAX_CHIPS = srcd_pkg::MAX_CHIPS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [3:0]                                     chip_count,
   input  logic                                           req_valid,
   output logic                                           req_ready,
   input  srcd_pkg::req_type                              req_data,
   output logic                                           rsp_valid,
   input  logic                                           rsp_ready,
   output srcd_pkg::rsp_type                              rsp_data,
   output srcd_pkg::mem_ctl_type                          mem_ctl,
   output logic [((MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1)-1:0] mem_addr,
   output logic [7:0]                                     mem_wdata,
   input  logic [7:0]                                     mem_rdata
);
   import srcd_pkg::*;

   localparam int         ADDR_W = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;
   localparam logic [3:0] MAX4   = 4'(MAX_CHIPS);

   state_type         state_ff, state_in;
   req_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [2:0]        bit_ff, bit_in;
   logic [7:0]        shift_ff, shift_in;

   logic [3:0]        live;
   logic [ADDR_W-1:0] last_idx;
   logic [2:0]        byte_no;
   logic              byte_ok;
   logic              req_drop;
   logic              is_set;
   logic [7:0]        bit_mask;
   logic              req_fire;
   logic              rsp_fire;
   logic              final_bit;

   always_comb begin
      if (chip_count == 4'd0) begin
         live = 4'd1;
      end else if (chip_count > MAX4) begin
         live = MAX4;
      end else begin
         live = chip_count;
      end
   end

   assign last_idx  = ADDR_W'(live - 4'd1);
   assign byte_no   = cmd_ff.bit_index[5:3];
   assign byte_ok   = {1'b0, byte_no} < MAX4;
   assign is_set    = cmd_ff.func == FUNC_SET_BIT;
   assign bit_mask  = BIT_ONE << cmd_ff.bit_index[2:0];
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign final_bit = (cur_ff == '0) && (bit_ff == BIT_LAST);

   // drop requests that give no bits
   always_comb begin
      req_drop = 1'b0;
      if (req_data.func > FUNC_CLEAR_BIT) begin
         req_drop = 1'b1;
      end else if (req_data.func == FUNC_WRITE_BYTE || req_data.func == FUNC_CLEAR_CHIP) begin
         req_drop = (req_data.chip_index == 4'd0) || (req_data.chip_index > MAX4);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req_drop) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (cmd_ff.func == FUNC_SET_ALL || cmd_ff.func == FUNC_CLEAR_ALL) begin
               state_in = ST_FILL;
            end else if ((cmd_ff.func == FUNC_SET_BIT || cmd_ff.func == FUNC_CLEAR_BIT)
                         && byte_ok) begin
               state_in = ST_MODIFY;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_FILL: begin
            if (fill_ff == last_idx) begin
               state_in = ST_PREP;
            end
         end
         ST_MODIFY: state_in = ST_PREP;
         ST_PREP:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (rsp_fire && final_bit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      mem_ctl   = '0;
      mem_addr  = '0;
      mem_wdata = BYTE_ZERO;
      cmd_in    = cmd_ff;
      fill_in   = fill_ff;
      cur_in    = cur_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd_in  = req_data;
               fill_in = '0;
            end
         end
         ST_EXEC: begin
            if (cmd_ff.func == FUNC_WRITE_BYTE || cmd_ff.func == FUNC_CLEAR_CHIP) begin
               mem_ctl.wr = 1'b1;
               mem_addr   = ADDR_W'(cmd_ff.chip_index - 4'd1);
               mem_wdata  = (cmd_ff.func == FUNC_WRITE_BYTE) ? cmd_ff.data_byte : BYTE_ZERO;
            end else if ((cmd_ff.func == FUNC_SET_BIT || cmd_ff.func == FUNC_CLEAR_BIT)
                         && byte_ok) begin
               mem_ctl.rd = 1'b1;
               mem_addr   = ADDR_W'(byte_no);
            end
         end
         ST_FILL: begin
            mem_ctl.wr = 1'b1;
            mem_addr   = fill_ff;
            mem_wdata  = (cmd_ff.func == FUNC_SET_ALL) ? BYTE_ONES : BYTE_ZERO;
            fill_in    = fill_ff + 1'b1;
         end
         ST_MODIFY: begin
            mem_ctl.wr = 1'b1;
            mem_addr   = ADDR_W'(byte_no);
            mem_wdata  = is_set ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
         end
         ST_PREP: begin
            mem_ctl.rd = 1'b1;
            mem_addr   = last_idx;
            cur_in     = last_idx;
         end
         ST_LOAD: begin
            shift_in = mem_rdata;
            bit_in   = '0;
            // prefetch the next chip down while this one shifts
            if (cur_ff != '0) begin
               mem_ctl.rd = 1'b1;
               mem_addr   = cur_ff - 1'b1;
            end
         end
         ST_SHIFT: begin
            rsp_valid = 1'b1;
            if (rsp_fire) begin
               if (bit_ff == BIT_LAST) begin
                  if (cur_ff != '0) begin
                     cur_in   = cur_ff - 1'b1;
                     shift_in = mem_rdata;
                     bit_in   = '0;
                     if (cur_ff != ADDR_W'(1)) begin
                        mem_ctl.rd = 1'b1;
                        mem_addr   = cur_ff - ADDR_W'(2);
                     end
                  end
               end else begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_ff + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         cur_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cur_ff   <= cur_in;
         bit_ff   <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      shift_ff <= shift_in;
   end

   assign rsp_data.serial_bit = shift_ff[7];
   assign rsp_data.last       = final_bit;

   `ASSERT_IMPLIES(a_busy_blocks_req, clock, reset, state_ff != ST_IDLE, !req_ready,
                   "request taken while busy")
   `ASSERT_NEXT(a_last_ends_cmd, clock, reset, rsp_fire && rsp_data.last,
                state_ff == ST_IDLE, "sequencer did not return to idle after last bit")
   `ASSERT_IMPLIES(a_single_port, clock, reset, mem_ctl.wr, !mem_ctl.rd,
                   "read and write issued together")
   `ASSERT_IMPLIES(a_no_write_shift, clock, reset, rsp_valid, !mem_ctl.wr,
                   "shadow written during shift out")
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import srcd_pkg::*;

   localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
   localparam int CHIP_LIMIT = MAX_CHIPS_DEF;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASES = 6;
   localparam int PHASE_COMMANDS = 14;
   localparam int ROWS = 28;

   typedef enum logic [1:0] {ROW_CMD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHAIN_MODEL, CHAIN_FILL, CHAIN_NONE} chain_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [2:0]     func;
      logic [3:0]     chip;
      logic [7:0]     data;
      logic [5:0]     bit_no;
      logic [3:0]     csr_value;
      chain_kind_type how;
      logic [7:0]     fill;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   req_type    req_data = '0;
   logic       rsp_ready = 1'b0;
   logic       csr_valid = 1'b0;
   logic [3:0] csr_data = '0;
   logic       req_ready;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_ready;

   logic [7:0] shadow_model [CHIP_LIMIT];
   logic [3:0] chip_cfg;
   rsp_type    pending_bits [$];
   int         flaws = 0;
   int         quiet_cycles = 0;
   int         rx_hold = 1;
   logic       rx_calm = 1'b0;
   logic       tx_calm = 1'b0;

   // FILL rows: every live chip shifts out the same byte
   row_type directed_rows [ROWS] = '{
      '{ROW_CMD, FUNC_SET_ALL,    4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_FILL,  8'hff},
      '{ROW_CMD, FUNC_CLEAR_ALL,  4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_FILL,  8'h00},
      '{ROW_CMD, FUNC_WRITE_BYTE, 4'd1,  8'hff, 6'd0,  4'd0,  CHAIN_FILL,  8'hff},
      '{ROW_CMD, FUNC_WRITE_BYTE, 4'd1,  8'h00, 6'd63, 4'd0,  CHAIN_FILL,  8'h00},
      '{ROW_CMD, FUNC_WRITE_BYTE, 4'd0,  8'h5a, 6'd0,  4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_WRITE_BYTE, 4'd9,  8'ha5, 6'd0,  4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_CLEAR_CHIP, 4'd15, 8'h00, 6'd0,  4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_CLEAR_CHIP, 4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_SPARE_6,    4'd1,  8'h12, 6'd5,  4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_SPARE_7,    4'd8,  8'hff, 6'd63, 4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_SET_BIT,    4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_FILL,  8'h01},
      '{ROW_CMD, FUNC_SET_BIT,    4'd0,  8'h00, 6'd7,  4'd0,  CHAIN_FILL,  8'h81},
      '{ROW_CMD, FUNC_CLEAR_BIT,  4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_FILL,  8'h80},
      '{ROW_CMD, FUNC_WRITE_BYTE, 4'd8,  8'h3c, 6'd0,  4'd0,  CHAIN_FILL,  8'h80},
      '{ROW_CMD, FUNC_SET_BIT,    4'd0,  8'h00, 6'd63, 4'd0,  CHAIN_FILL,  8'h80},
      '{ROW_CSR, FUNC_WRITE_BYTE, 4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_CLEAR_BIT,  4'd0,  8'h00, 6'd7,  4'd0,  CHAIN_FILL,  8'h00},
      '{ROW_CSR, FUNC_WRITE_BYTE, 4'd0,  8'h00, 6'd0,  4'd8,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_SET_ALL,    4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_FILL,  8'hff},
      '{ROW_CMD, FUNC_CLEAR_CHIP, 4'd8,  8'h00, 6'd0,  4'd0,  CHAIN_MODEL, 8'h00},
      '{ROW_CMD, FUNC_CLEAR_BIT,  4'd0,  8'h00, 6'd63, 4'd0,  CHAIN_MODEL, 8'h00},
      '{ROW_CSR, FUNC_WRITE_BYTE, 4'd0,  8'h00, 6'd0,  4'd15, CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_WRITE_BYTE, 4'd3,  8'h96, 6'd0,  4'd0,  CHAIN_MODEL, 8'h00},
      '{ROW_CSR, FUNC_WRITE_BYTE, 4'd0,  8'h00, 6'd0,  4'd3,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_CLEAR_ALL,  4'd0,  8'h00, 6'd0,  4'd0,  CHAIN_MODEL, 8'h00},
      '{ROW_CMD, FUNC_SET_BIT,    4'd0,  8'h00, 6'd42, 4'd0,  CHAIN_MODEL, 8'h00},
      '{ROW_CSR, FUNC_WRITE_BYTE, 4'd0,  8'h00, 6'd0,  4'd8,  CHAIN_NONE,  8'h00},
      '{ROW_CMD, FUNC_CLEAR_BIT,  4'd0,  8'h00, 6'd56, 4'd0,  CHAIN_MODEL, 8'h00}
   };

   shift_register_chain_driver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int live_chips();
      if (chip_cfg == 4'd0) return 1;
      if (chip_cfg > CHIP_LIMIT) return CHIP_LIMIT;
      return int'(chip_cfg);
   endfunction

   // Update the shadow, give the chain image (first bit at [0]), return its bit count
   function automatic int apply_command(req_type r, output logic [63:0] stream);
      int n;
      int k;
      int byte_no;
      logic [7:0] mask;
      n = live_chips();
      stream = '0;
      byte_no = int'(r.bit_index) / BITS_PER_CHIP;
      mask = BIT_ONE << r.bit_index[2:0];
      case (r.func)
         FUNC_WRITE_BYTE, FUNC_CLEAR_CHIP: begin
            if (r.chip_index == 4'd0 || r.chip_index > CHIP_LIMIT) return 0;
            shadow_model[int'(r.chip_index) - 1] =
               (r.func == FUNC_WRITE_BYTE) ? r.data_byte : BYTE_ZERO;
         end
         FUNC_SET_ALL, FUNC_CLEAR_ALL: begin
            for (k = 0; k < n; k++)
               shadow_model[k] = (r.func == FUNC_SET_ALL) ? BYTE_ONES : BYTE_ZERO;
         end
         FUNC_SET_BIT: begin
            if (byte_no < CHIP_LIMIT) shadow_model[byte_no] = shadow_model[byte_no] | mask;
         end
         FUNC_CLEAR_BIT: begin
            if (byte_no < CHIP_LIMIT) shadow_model[byte_no] = shadow_model[byte_no] & ~mask;
         end
         default: return 0;
      endcase
      for (k = 0; k < BITS_PER_CHIP * n; k++)
         stream[k] = shadow_model[n - 1 - k / BITS_PER_CHIP][7 - k % BITS_PER_CHIP];
      return BITS_PER_CHIP * n;
   endfunction

   task automatic queue_chain(logic [63:0] stream, int nbits);
      rsp_type e;
      for (int k = 0; k < nbits; k++) begin
         e.serial_bit = stream[k];
         e.last = (k == nbits - 1);
         pending_bits.push_back(e);
      end
   endtask

   // Drop valid and let the chain drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_chip_count(logic [3:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chip_cfg = value;
   endtask

   task automatic issue_command(req_type r, chain_kind_type how, logic [7:0] fill,
                                output int nbits);
      logic [63:0] stream;
      logic [63:0] typed;
      int gap;
      int k;
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      nbits = apply_command(r, stream);
      case (how)
         CHAIN_MODEL: queue_chain(stream, nbits);
         CHAIN_FILL: begin
            typed = '0;
            for (k = 0; k < BITS_PER_CHIP * live_chips(); k++)
               typed[k] = fill[7 - k % BITS_PER_CHIP];
            queue_chain(typed, BITS_PER_CHIP * live_chips());
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : take_bit
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_hold = 1;
      end else if (rsp_valid && rsp_ready) begin
         if (pending_bits.size() == 0) begin
            if (flaws < 10)
               $display("unexpected bit: serial_bit %b last %b", rsp_data.serial_bit,
                        rsp_data.last);
            flaws++;
         end else begin
            want = pending_bits.pop_front();
            if (rsp_data !== want) begin
               if (flaws < 10)
                  $display("bit mismatch: serial_bit exp %b got %b, last exp %b got %b",
                           want.serial_bit, rsp_data.serial_bit, want.last, rsp_data.last);
               flaws++;
            end
         end
         if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
         rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
         rsp_ready <= (rx_hold == 0);
      end else if (!rsp_ready) begin
         if (rx_hold <= 1) rsp_ready <= 1'b1;
         rx_hold = rx_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_type cmd;
      int nbits;
      int done_cmds;
      int pick;
      logic [3:0] phase_cfg;
      for (int i = 0; i < CHIP_LIMIT; i++) shadow_model[i] = BYTE_ZERO;
      chip_cfg = 4'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_chip_count(directed_rows[i].csr_value);
         end else begin
            cmd.func = directed_rows[i].func;
            cmd.chip_index = directed_rows[i].chip;
            cmd.data_byte = directed_rows[i].data;
            cmd.bit_index = directed_rows[i].bit_no;
            issue_command(cmd, directed_rows[i].how, directed_rows[i].fill, nbits);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: phase_cfg = 4'd1;
            1: phase_cfg = 4'd8;
            2: phase_cfg = 4'd0;
            3: phase_cfg = 4'd15;
            default: phase_cfg = 4'($urandom_range(0, 15));
         endcase
         write_chip_count(phase_cfg);
         done_cmds = 0;
         while (done_cmds < PHASE_COMMANDS) begin
            // hold off mid-phase until the chain has fully drained
            if (phase == 2 && done_cmds == PHASE_COMMANDS / 2) settle();
            pick = $urandom_range(0, 99);
            if (pick < 6)
               cmd.func = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_7 : FUNC_SPARE_6;
            else
               cmd.func = 3'($urandom_range(FUNC_WRITE_BYTE, FUNC_CLEAR_BIT));
            if (pick >= 6 && pick < 10)
               cmd.chip_index = 4'd0;
            else if (pick >= 10 && pick < 14)
               cmd.chip_index = 4'($urandom_range(CHIP_LIMIT + 1, 15));
            else
               cmd.chip_index = 4'($urandom_range(1, CHIP_LIMIT));
            cmd.data_byte = 8'($urandom_range(0, 255));
            // aim most bit commands at chips that are shifted out
            if ($urandom_range(0, 3) != 0)
               cmd.bit_index = 6'($urandom_range(0, BITS_PER_CHIP * live_chips() - 1));
            else
               cmd.bit_index = 6'($urandom_range(0, 63));
            issue_command(cmd, CHAIN_MODEL, BYTE_ZERO, nbits);
            if (nbits != 0) done_cmds++;
         end
      end

      settle();
      if (flaws == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/srcd_pkg.sv
rtl/srcd_ram.sv
rtl/srcd_shadow.sv
rtl/srcd_seq.sv
rtl/shift_register_chain_driver.sv
test/tb.sv
